/* sv/avrc_pkg.sv */
// Package of the adjusted value range classifier.
// Holds the configuration register indexes, adjustment mode codes, state encoding
// and the range table entry type. No dependencies.
package avrc_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SHIFT_AMOUNT     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_AND_MASK         = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ADD_ENABLE       = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ADD_OFFSET       = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ADJUST_MODE      = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_DIVISOR          = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_RANGE_COUNT      = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_GROUP_ID = 3'd7;

	// Adjustment modes; the unused code behaves as no adjustment
	localparam logic [1:0] MODE_NONE = 2'd0;
	localparam logic [1:0] MODE_DIV  = 2'd1;
	localparam logic [1:0] MODE_REM  = 2'd2;

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_PREP   = 6'b000010,
		ST_DIVIDE = 6'b000100,
		ST_ADJUST = 6'b001000,
		ST_SCAN   = 6'b010000,
		ST_HOLD   = 6'b100000
	} state_t;

	typedef struct packed {
		logic [31:0] low;
		logic [31:0] high;
		logic [15:0] group;
	} range_entry_t;

endpackage

/* sv/adjusted_value_range_classifier_top.sv */
// Top level of the adjusted value range classifier: value adjustment, iterative
// divider, range table memory and sequential range scan.
// Depends on avrc_pkg.
//
//   channel  | direction | handshake             | payload
//   ---------+-----------+-----------------------+------------------------------------------
//   in       | into      | in_valid / in_stall   | kind, sample_value, entry_index, entry_*
//   out      | out of    | out_valid / out_stall | group_id, matched, divide_by_zero
//   cfg      | into      | cfg_we                | cfg_index, cfg_data
//
// A table write goes straight into the table memory. A classify item passes a
// preparation step, with division also the 32-step divider and an adjustment
// step, and then the scan of the table memory, one entry per cycle over the
// searched range count. A zero divisor ends the item right after preparation.
// Reset clears the configuration to its defaults; the table is not cleared.
// While an item is at work in_stall is high; a finished result waits in the output
// register, and the block takes the next item while that result is stalled.
module adjusted_value_range_classifier_top #(
	parameter int MAX_RANGES = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              kind,
	input  logic signed [31:0]                sample_value,
	input  logic [3:0]                        entry_index,
	input  logic [31:0]                       entry_low,
	input  logic [31:0]                       entry_high,
	input  logic [15:0]                       entry_group,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [15:0]                       group_id,
	output logic                              matched,
	output logic                              divide_by_zero,
	input  logic                              cfg_we,
	input  logic [avrc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [avrc_pkg::CFG_DATA_W-1:0]   cfg_data
);

	localparam int IDX_W = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
	localparam int CNT_W = $clog2(MAX_RANGES + 1);

	// Configuration registers
	logic [4:0]         shift_amount_q;
	logic [31:0]        and_mask_q;
	logic               add_enable_q;
	logic signed [7:0]  add_offset_q;
	logic [1:0]         adjust_mode_q;
	logic signed [7:0]  divisor_q;
	logic [4:0]         range_count_q;
	logic [15:0]        default_group_q;

	avrc_pkg::state_t   state_q;

	logic [31:0]        v_q;
	logic               vneg_q;
	logic [31:0]        mag_q;
	logic [7:0]         rem_q;
	logic [4:0]         step_q;
	logic [CNT_W-1:0]   scan_q;
	logic               cmp_vld_s1;
	logic               last_s1;
	logic [15:0]        res_group_q;
	logic               res_matched_q;
	logic               res_dbz_q;
	logic               out_valid_q;
	logic [15:0]        group_id_q;
	logic               matched_q;
	logic               dbz_q;

	avrc_pkg::range_entry_t mem [MAX_RANGES];
	avrc_pkg::range_entry_t rd_s1;

	logic               in_xfer;
	logic               tbl_we;
	logic signed [31:0] shifted;
	logic [31:0]        masked;
	logic [31:0]        adjusted;
	logic               div_mode;
	logic               dneg;
	logic [7:0]         dmag;
	logic [8:0]         partial;
	logic [9:0]         diff;
	logic               fits;
	logic [CNT_W-1:0]   n_eff;
	logic               hit;
	logic               scan_done;
	logic               out_free;

	assign in_xfer  = in_valid && !in_stall;
	assign in_stall = (state_q != avrc_pkg::ST_IDLE);
	assign tbl_we   = in_xfer && kind && (32'(entry_index) < 32'(MAX_RANGES));

	// Shift, mask and offset of the incoming sample
	assign shifted  = sample_value >>> shift_amount_q;
	assign masked   = shifted & and_mask_q;
	assign adjusted = add_enable_q ? masked + {{24{add_offset_q[7]}}, add_offset_q} : masked;

	assign div_mode = (adjust_mode_q == avrc_pkg::MODE_DIV) ||
		(adjust_mode_q == avrc_pkg::MODE_REM);
	assign dneg     = divisor_q[7];
	assign dmag     = dneg ? 8'(8'd0 - divisor_q) : divisor_q;

	// One restoring step of the magnitude division
	assign partial  = {rem_q, mag_q[31]};
	assign diff     = {1'b0, partial} - {2'b00, dmag};
	assign fits     = !diff[9];

	assign n_eff    = (32'(range_count_q) > 32'(MAX_RANGES)) ? CNT_W'(MAX_RANGES)
		: CNT_W'(range_count_q);
	assign hit      = (rd_s1.low <= v_q) && (v_q <= rd_s1.high);
	// The scan ends on a hit, after the last compare, or at once when nothing is searched.
	assign scan_done = (cmp_vld_s1 && (hit || last_s1)) || (!cmp_vld_s1 && (scan_q == n_eff));
	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_amount_q  <= 5'd0;
			and_mask_q      <= 32'd255;
			add_enable_q    <= 1'b0;
			add_offset_q    <= 8'sd0;
			adjust_mode_q   <= avrc_pkg::MODE_NONE;
			divisor_q       <= 8'sd1;
			range_count_q   <= 5'd0;
			default_group_q <= 16'd0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				avrc_pkg::REG_SHIFT_AMOUNT:     shift_amount_q  <= cfg_data[4:0];
				avrc_pkg::REG_AND_MASK:         and_mask_q      <= cfg_data[31:0];
				avrc_pkg::REG_ADD_ENABLE:       add_enable_q    <= cfg_data[0];
				avrc_pkg::REG_ADD_OFFSET:       add_offset_q    <= cfg_data[7:0];
				avrc_pkg::REG_ADJUST_MODE:      adjust_mode_q   <= cfg_data[1:0];
				avrc_pkg::REG_DIVISOR:          divisor_q       <= cfg_data[7:0];
				avrc_pkg::REG_RANGE_COUNT:      range_count_q   <= cfg_data[4:0];
				avrc_pkg::REG_DEFAULT_GROUP_ID: default_group_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// Range table: one write port for table items, one registered read port for the scan
	always_ff @(posedge clk) begin
		if (tbl_we) begin
			mem[IDX_W'(entry_index)] <= '{low: entry_low, high: entry_high, group: entry_group};
		end
		rd_s1 <= mem[scan_q[IDX_W-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= avrc_pkg::ST_IDLE;
			cmp_vld_s1  <= 1'b0;
			last_s1     <= 1'b0;
			scan_q      <= '0;
			step_q      <= 5'd0;
			out_valid_q <= 1'b0;
		end else begin
			cmp_vld_s1 <= (state_q == avrc_pkg::ST_SCAN) && !scan_done;
			if ((state_q == avrc_pkg::ST_HOLD) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				avrc_pkg::ST_IDLE: begin
					if (in_xfer && !kind) begin
						state_q <= avrc_pkg::ST_PREP;
					end
				end
				avrc_pkg::ST_PREP: begin
					scan_q <= '0;
					step_q <= 5'd31;
					if (div_mode && (dmag == 8'd0)) begin
						state_q <= avrc_pkg::ST_HOLD;
					end else if (div_mode) begin
						state_q <= avrc_pkg::ST_DIVIDE;
					end else begin
						state_q <= avrc_pkg::ST_SCAN;
					end
				end
				avrc_pkg::ST_DIVIDE: begin
					step_q <= step_q - 5'd1;
					if (step_q == 5'd0) begin
						state_q <= avrc_pkg::ST_ADJUST;
					end
				end
				avrc_pkg::ST_ADJUST: begin
					state_q <= avrc_pkg::ST_SCAN;
				end
				avrc_pkg::ST_SCAN: begin
					if (scan_done) begin
						state_q <= avrc_pkg::ST_HOLD;
					end else begin
						last_s1    <= (({1'b0, scan_q} + 1'b1) == {1'b0, n_eff});
						scan_q     <= CNT_W'(scan_q + 1'b1);
					end
				end
				avrc_pkg::ST_HOLD: begin
					if (out_free) begin
						state_q     <= avrc_pkg::ST_IDLE;
					end
				end
				default: state_q <= avrc_pkg::ST_IDLE;
			endcase
		end
	end

	// Datapath and result registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			avrc_pkg::ST_IDLE: begin
				if (in_xfer) begin
					v_q <= adjusted;
				end
			end
			avrc_pkg::ST_PREP: begin
				vneg_q        <= v_q[31];
				mag_q         <= v_q[31] ? 32'd0 - v_q : v_q;
				rem_q         <= 8'd0;
				res_group_q   <= default_group_q;
				res_matched_q <= 1'b0;
				res_dbz_q     <= div_mode && (dmag == 8'd0);
			end
			avrc_pkg::ST_DIVIDE: begin
				rem_q <= fits ? diff[7:0] : partial[7:0];
				mag_q <= {mag_q[30:0], fits};
			end
			avrc_pkg::ST_ADJUST: begin
				// Quotient truncates toward zero; the remainder follows the dividend's sign.
				if (adjust_mode_q == avrc_pkg::MODE_DIV) begin
					v_q <= (vneg_q ^ dneg) ? 32'd0 - mag_q : mag_q;
				end else begin
					v_q <= vneg_q ? 32'd0 - {24'd0, rem_q} : {24'd0, rem_q};
				end
			end
			avrc_pkg::ST_SCAN: begin
				if (cmp_vld_s1 && hit) begin
					res_group_q   <= rd_s1.group;
					res_matched_q <= 1'b1;
				end
			end
			avrc_pkg::ST_HOLD: begin
				if (out_free) begin
					group_id_q <= res_group_q;
					matched_q  <= res_matched_q;
					dbz_q      <= res_dbz_q;
				end
			end
			default: ;
		endcase
	end

	assign out_valid      = out_valid_q;
	assign group_id       = group_id_q;
	assign matched        = matched_q;
	assign divide_by_zero = dbz_q;

endmodule

/* sv/avrc_checker.sv */
// Port-level checker of the adjusted value range classifier, with its bind.
// Watches only the top level's ports; depends on adjusted_value_range_classifier_top.
module avrc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        kind,
	input logic        out_valid,
	input logic        out_stall,
	input logic [15:0] group_id,
	input logic        matched,
	input logic        divide_by_zero
);

	// A stalled result holds until its transfer.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(group_id) && $stable(matched)
			&& $stable(divide_by_zero))
		else $error("stalled result changed");

	// A zero divisor never reports a table match.
	a_dbz_no_match: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && divide_by_zero |-> !matched)
		else $error("divide by zero reported with a match");

	// A classify transfer keeps the block busy in the following cycle.
	a_classify_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && !kind |=> in_stall)
		else $error("block not busy after a classify transfer");

	// A table write produces no result.
	a_write_silent: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && kind && !out_valid |=> !out_valid)
		else $error("result appeared after a table write");

endmodule

bind adjusted_value_range_classifier_top avrc_checker u_avrc_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (in_valid),
	.in_stall       (in_stall),
	.kind           (kind),
	.out_valid      (out_valid),
	.out_stall      (out_stall),
	.group_id       (group_id),
	.matched        (matched),
	.divide_by_zero (divide_by_zero)
);
